// ===== hw/rtl/grt_pkg.sv =====
// Shared types and codes for the guest region table.
`default_nettype none
package grt_pkg;
    localparam int AMAX = 64;
    localparam int EMAX = AMAX + 1;
    localparam int CMAX = 9;

    typedef logic [AMAX-1:0] addr_t;
    typedef logic [EMAX-1:0] end_t;
    typedef logic [CMAX-1:0] cnt_t;

    localparam logic [2:0] OP_MAP           = 3'd0;
    localparam logic [2:0] OP_UNMAP         = 3'd1;
    localparam logic [2:0] OP_UNMAP_RANGE   = 3'd2;
    localparam logic [2:0] OP_PROTECT       = 3'd3;
    localparam logic [2:0] OP_PROTECT_RANGE = 3'd4;
    localparam logic [2:0] OP_CHECK         = 3'd5;
    localparam logic [2:0] OP_FIND          = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RANGE = 3'd1;
    localparam logic [2:0] ST_OVERLAP   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_NO_PERM   = 3'd4;
    localparam logic [2:0] ST_BOUNDS    = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    typedef struct packed {
        addr_t       base;
        logic [31:0] len;
        logic [2:0]  rights;
    } piece_t;

    typedef struct packed {
        addr_t       addr;
        logic [31:0] len;
        logic [2:0]  rights;
        logic [2:0]  op;
    } req_t;

    typedef struct packed {
        logic         active;
        logic         overlap;
        logic         xhit;
        logic         found;
        cnt_t         used;
        cnt_t         removed;
        logic [1:0]   np;
        piece_t       fnd;
        piece_t [1:0] pc;
    } scan_t;

    typedef struct packed {
        logic         active;
        logic         setr;
        logic [1:0]   cnt;
        piece_t [2:0] q;
    } commit_t;
endpackage
`default_nettype wire

// ===== hw/rtl/grt_cell.sv =====
// One table slot: holds a region and passes the scan and commit tokens on.
`default_nettype none
module grt_cell #(
    parameter int ADDR_BITS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire grt_pkg::req_t    req,
    input  wire grt_pkg::scan_t   scan_in,
    input  wire grt_pkg::commit_t commit_in,
    output grt_pkg::scan_t        scan_out,
    output grt_pkg::commit_t      commit_out
);
    logic                 valid_reg, valid_next;
    logic                 mark_reg;
    logic [ADDR_BITS-1:0] base_reg, base_next;
    logic [31:0]          len_reg, len_next;
    logic [2:0]           rights_reg, rights_next;
    grt_pkg::scan_t       scan_reg, scan_next;
    grt_pkg::commit_t     commit_reg, commit_next;

    grt_pkg::end_t eb, ee, a, e;
    logic          contains, exact, ovl, mark;

    always_comb
    begin
        eb       = grt_pkg::end_t'(base_reg);
        ee       = eb + grt_pkg::end_t'(len_reg);
        a        = grt_pkg::end_t'(req.addr);
        e        = a + grt_pkg::end_t'(req.len);
        contains = valid_reg && (eb <= a) && (a < ee);
        exact    = valid_reg && (eb == a) && (len_reg == req.len);
        ovl      = valid_reg && (eb < e) && (a < ee);
        case (req.op) inside
            grt_pkg::OP_UNMAP, grt_pkg::OP_PROTECT: mark = exact;
            grt_pkg::OP_UNMAP_RANGE:                mark = ovl;
            grt_pkg::OP_PROTECT_RANGE:              mark = contains;
            default:                                mark = 1'b0;
        endcase
    end

    always_comb
    begin
        scan_next = scan_in;
        if (valid_reg)
        begin
            scan_next.used = grt_pkg::cnt_t'(scan_in.used + 1'b1);
        end
        if (exact)
        begin
            scan_next.xhit = 1'b1;
        end
        if (contains && !scan_in.found)
        begin
            scan_next.found       = 1'b1;
            scan_next.fnd.base    = grt_pkg::addr_t'(base_reg);
            scan_next.fnd.len     = len_reg;
            scan_next.fnd.rights  = rights_reg;
        end
        if (ovl)
        begin
            scan_next.overlap = 1'b1;
            scan_next.removed = grt_pkg::cnt_t'(scan_in.removed + 1'b1);
            if (a > eb && scan_next.np < 2'd2)
            begin
                scan_next.pc[scan_next.np[0]].base   = grt_pkg::addr_t'(base_reg);
                scan_next.pc[scan_next.np[0]].len    = 32'(a - eb);
                scan_next.pc[scan_next.np[0]].rights = rights_reg;
                scan_next.np = scan_next.np + 2'd1;
            end
            if (e < ee && scan_next.np < 2'd2)
            begin
                scan_next.pc[scan_next.np[0]].base   = grt_pkg::addr_t'(e);
                scan_next.pc[scan_next.np[0]].len    = 32'(ee - e);
                scan_next.pc[scan_next.np[0]].rights = rights_reg;
                scan_next.np = scan_next.np + 2'd1;
            end
        end
        scan_next.active = scan_in.active;
    end

    always_comb
    begin
        commit_next = commit_in;
        valid_next  = valid_reg;
        base_next   = base_reg;
        len_next    = len_reg;
        rights_next = rights_reg;
        if (commit_in.active && mark_reg)
        begin
            if (commit_in.setr)
            begin
                rights_next = req.rights;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
        if (commit_in.active && !valid_next && commit_in.cnt != 2'd0)
        begin
            valid_next      = 1'b1;
            base_next       = commit_in.q[0].base[ADDR_BITS-1:0];
            len_next        = commit_in.q[0].len;
            rights_next     = commit_in.q[0].rights;
            commit_next.q[0] = commit_in.q[1];
            commit_next.q[1] = commit_in.q[2];
            commit_next.cnt  = commit_in.cnt - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            mark_reg   <= 1'b0;
            scan_reg   <= '0;
            commit_reg <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            scan_reg   <= scan_next;
            commit_reg <= commit_next;
            if (scan_in.active)
            begin
                mark_reg <= mark;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg   <= base_next;
        len_reg    <= len_next;
        rights_reg <= rights_next;
    end

    assign scan_out   = scan_reg;
    assign commit_out = commit_reg;
endmodule
`default_nettype wire

// ===== hw/rtl/guest_region_table.sv =====
// Guest region table top level: request control and the chain of slot cells.
//
// One request beat on the input channel (in_valid/in_stall) gives exactly one
// result beat on the output channel (out_valid/out_stall). Requests are taken
// one at a time: in_stall stays high from acceptance until the result has been
// loaded into the output register, which may still hold the previous result.
// A scan token walks the slot chain one cell per cycle, collecting lookups,
// overlaps and used-slot counts; a request that changes the table then sends
// a commit token down the chain, which clears, retags and fills slots in
// slot order. The next request is taken in the cycle after the result is
// loaded. Reset empties the table at once; no sweep is needed. While the
// receiver stalls, the result holds in the output register and in_stall stays
// high until the register is free.
`default_nettype none
module guest_region_table #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  operation,
    input  wire logic [31:0] address,
    input  wire logic [31:0] length,
    input  wire logic [2:0]  rights,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [31:0]      found_base,
    output logic [31:0]      found_length,
    output logic [2:0]       found_rights
);
    localparam grt_pkg::addr_t AMASK = {grt_pkg::AMAX{1'b1}} >> (grt_pkg::AMAX - ADDR_BITS);
    localparam int             CW    = grt_pkg::CMAX + 1;
    localparam logic [CW-1:0]  ENT   = CW'(ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic              start_reg;
    grt_pkg::req_t     req_reg;
    logic [2:0]        st_reg, st_next;
    grt_pkg::piece_t   res_reg, res_next;
    logic              out_valid_reg;
    logic [2:0]        status_reg;
    grt_pkg::piece_t   out_reg;

    grt_pkg::scan_t    s_chain [ENTRIES+1];
    grt_pkg::commit_t  c_chain [ENTRIES+1];
    grt_pkg::scan_t    s_head;
    grt_pkg::scan_t    acc;
    grt_pkg::commit_t  ct;

    grt_pkg::end_t     a, e, fee;
    logic              rok;
    logic [CW-1:0]     need;
    logic [1:0]        k;
    grt_pkg::piece_t   mid;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            grt_cell #(.ADDR_BITS(ADDR_BITS)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .req        (req_reg),
                .scan_in    (s_chain[gi]),
                .commit_in  (c_chain[gi]),
                .scan_out   (s_chain[gi+1]),
                .commit_out (c_chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        s_head        = '0;
        s_head.active = start_reg;
    end

    assign s_chain[0] = s_head;

    assign acc = s_chain[ENTRIES];

    always_comb
    begin
        a        = grt_pkg::end_t'(req_reg.addr);
        e        = a + grt_pkg::end_t'(req_reg.len);
        fee      = grt_pkg::end_t'(acc.fnd.base) + grt_pkg::end_t'(acc.fnd.len);
        rok      = (req_reg.len != 32'd0) && (e <= grt_pkg::end_t'(AMASK));
        mid.base   = req_reg.addr;
        mid.len    = req_reg.len;
        mid.rights = req_reg.rights;
        st_next  = grt_pkg::ST_BAD_RANGE;
        res_next = '0;
        ct       = '0;
        need     = '0;
        k        = 2'd0;
        unique case (req_reg.op) inside
            grt_pkg::OP_MAP:
            begin
                if (!rok)
                    st_next = grt_pkg::ST_BAD_RANGE;
                else if (acc.overlap)
                    st_next = grt_pkg::ST_OVERLAP;
                else if (CW'(acc.used) >= ENT)
                    st_next = grt_pkg::ST_FULL;
                else
                begin
                    st_next  = grt_pkg::ST_OK;
                    ct.cnt   = 2'd1;
                    ct.q[0]  = mid;
                end
            end
            grt_pkg::OP_UNMAP, grt_pkg::OP_PROTECT:
            begin
                st_next = acc.xhit ? grt_pkg::ST_OK : grt_pkg::ST_NOT_FOUND;
                ct.setr = (req_reg.op == grt_pkg::OP_PROTECT);
            end
            grt_pkg::OP_UNMAP_RANGE:
            begin
                need = CW'(acc.used) - CW'(acc.removed) + CW'(acc.np);
                if (!rok)
                    st_next = grt_pkg::ST_BAD_RANGE;
                else if (need > ENT)
                    st_next = grt_pkg::ST_FULL;
                else
                begin
                    st_next = grt_pkg::ST_OK;
                    ct.cnt  = acc.np;
                    ct.q[0] = acc.pc[0];
                    ct.q[1] = acc.pc[1];
                end
            end
            grt_pkg::OP_PROTECT_RANGE:
            begin
                need = CW'(acc.used) + CW'(a > grt_pkg::end_t'(acc.fnd.base))
                     + CW'(e < fee);
                if (!rok)
                    st_next = grt_pkg::ST_BAD_RANGE;
                else if (!acc.found)
                    st_next = grt_pkg::ST_NOT_FOUND;
                else if (e > fee)
                    st_next = grt_pkg::ST_BOUNDS;
                else if (need > ENT)
                    st_next = grt_pkg::ST_FULL;
                else
                begin
                    st_next = grt_pkg::ST_OK;
                    if (a > grt_pkg::end_t'(acc.fnd.base))
                    begin
                        ct.q[k].base   = acc.fnd.base;
                        ct.q[k].len    = 32'(a - grt_pkg::end_t'(acc.fnd.base));
                        ct.q[k].rights = acc.fnd.rights;
                        k = k + 2'd1;
                    end
                    ct.q[k] = mid;
                    k = k + 2'd1;
                    if (e < fee)
                    begin
                        ct.q[k].base   = grt_pkg::addr_t'(e);
                        ct.q[k].len    = 32'(fee - e);
                        ct.q[k].rights = acc.fnd.rights;
                        k = k + 2'd1;
                    end
                    ct.cnt = k;
                end
            end
            grt_pkg::OP_CHECK:
            begin
                if (req_reg.len == 32'd0)
                    st_next = grt_pkg::ST_OK;
                else if (!acc.found)
                    st_next = grt_pkg::ST_NOT_FOUND;
                else
                begin
                    res_next = acc.fnd;
                    if ((acc.fnd.rights & req_reg.rights) != req_reg.rights)
                        st_next = grt_pkg::ST_NO_PERM;
                    else if (e > fee)
                        st_next = grt_pkg::ST_BOUNDS;
                    else
                        st_next = grt_pkg::ST_OK;
                end
            end
            grt_pkg::OP_FIND:
            begin
                if (acc.found)
                begin
                    st_next  = grt_pkg::ST_OK;
                    res_next = acc.fnd;
                end
                else
                    st_next = grt_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                st_next = grt_pkg::ST_BAD_RANGE;
            end
        endcase
        ct.active = (state_reg == S_SCAN) && acc.active && (st_next == grt_pkg::ST_OK)
                    && (req_reg.op != grt_pkg::OP_CHECK) && (req_reg.op != grt_pkg::OP_FIND)
                    && (req_reg.op <= grt_pkg::OP_FIND);
    end

    assign c_chain[0] = ct;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (acc.active)
                    state_next = ct.active ? S_COMMIT : S_DONE;
            end
            S_COMMIT:
            begin
                if (c_chain[ENTRIES].active)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == S_IDLE) && in_valid;
            if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            req_reg.op     <= operation;
            req_reg.addr   <= grt_pkg::addr_t'(address) & AMASK;
            req_reg.len    <= length;
            req_reg.rights <= rights;
        end
        if (state_reg == S_SCAN && acc.active)
        begin
            st_reg  <= st_next;
            res_reg <= res_next;
        end
        if (state_reg == S_DONE && (!out_valid_reg || !out_stall))
        begin
            status_reg <= st_reg;
            out_reg    <= res_reg;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found_base   = out_reg.base[31:0];
    assign found_length = out_reg.len;
    assign found_rights = out_reg.rights;
endmodule
`default_nettype wire
